### rtl/flptw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the four-level page table walker.
// No dependencies; used by the walker and the checker under rtl.
package flptw_pkg;

   // Default configuration
   localparam int TABLE_FRAMES_DEF = 64;
   localparam int PHYS_BITS_DEF    = 52;

   // Word field widths
   localparam int VA_W     = 48;
   localparam int PA_W     = 52;
   localparam int FLAGS_W  = 12;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Address split
   localparam int IDX_W     = 9;
   localparam int OFFSET_W  = 12;
   localparam int L4_SHIFT  = 39;
   localparam int L3_SHIFT  = 30;
   localparam int L2_SHIFT  = 21;
   localparam int L1_SHIFT  = 12;
   localparam logic [IDX_W-1:0] IDX_MASK = 9'h1FF;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_MASK;

   // Levels
   localparam logic [1:0] LVL_ROOT = 2'd0;
   localparam logic [1:0] LVL_LAST_LINK = 2'd2;
   localparam logic [1:0] LVL_LEAF = 2'd3;

   // Entry bits
   localparam int PRESENT_BIT = 0;
   localparam logic [OFFSET_W-1:0] LINK_FLAGS = 12'h003;   // write | present

   // Request codes
   localparam logic [ACTION_W-1:0] ACT_MAP    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UNMAP  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NOT_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NO_FRAMES   = 2'd2;
   localparam logic [STATUS_W-1:0] STS_BAD         = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VA_W-1:0]     virt_addr;
      logic [PA_W-1:0]     phys_addr;
      logic [FLAGS_W-1:0]  entry_flags;
   } req_word_type;

   typedef struct packed {
      logic [PA_W-1:0]     phys_result;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DECIDE,
      ST_LINK,
      ST_LEAF,
      ST_DONE
   } state_type;

endpackage

### rtl/flptw_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module flptw_ram #(
   parameter int DATA_W = 52,
   parameter int DEPTH  = 32768
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [DATA_W-1:0]          wdata,
   output logic [DATA_W-1:0]          rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// Four-level page table walker: sequencer plus table-frame store.
// Depends on flptw_pkg and flptw_ram.
//
// Usage
//   req channel: one word per request (map, unmap or lookup on a 48-bit VA).
//   rsp channel: exactly one word per request, in request order.
//   Both channels: word moves on a clock edge with valid high, stall low.
//   req_stall is high whenever the sequencer is busy; one request at a time.
// Sequence (accept to rsp_valid)
//   A read and an evaluate state per level through the single RAM port (up to 4
//   levels), then a decide state, any link or leaf writes, and the output register.
//   A map that allocates k new frames (k = 1..3) zeroes each fresh frame one entry
//   per cycle across its 512 entries before linking it.
//   The next request is accepted only after the result is in the output register.
// Reset
//   Synchronous, active high. Allocator restarts at frame 1, then the 512 entries
//   of the root frame are zeroed in a sweep; req_stall stays high until done.
//   Frames above the root are zeroed when taken, so no full-store sweep.
// Back-pressure
//   Result sits in an output register; while rsp_stall holds it the block
//   finishes nothing else, but the next request is accepted once the
//   sequencer is back in idle.
module four_level_page_table_walker #(
   parameter int TABLE_FRAMES = flptw_pkg::TABLE_FRAMES_DEF,
   parameter int PHYS_BITS    = flptw_pkg::PHYS_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  flptw_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output flptw_pkg::rsp_word_type rsp_word
);

   localparam int FRAME_W = $clog2(TABLE_FRAMES);
   localparam int NFF_W   = $clog2(TABLE_FRAMES + 1);
   localparam int ADDR_W  = FRAME_W + flptw_pkg::IDX_W;
   localparam int DEPTH   = TABLE_FRAMES * (1 << flptw_pkg::IDX_W);
   localparam int PAGE_W  = PHYS_BITS - flptw_pkg::OFFSET_W;

   // Table index for a given level of the walk
   function automatic logic [flptw_pkg::IDX_W-1:0] level_idx(
      input logic [flptw_pkg::VA_W-1:0] va,
      input logic [1:0]                 lvl
   );
      logic [flptw_pkg::IDX_W-1:0] idx;
      unique case (lvl)
         2'd0:    idx = va[flptw_pkg::L4_SHIFT +: flptw_pkg::IDX_W];
         2'd1:    idx = va[flptw_pkg::L3_SHIFT +: flptw_pkg::IDX_W];
         2'd2:    idx = va[flptw_pkg::L2_SHIFT +: flptw_pkg::IDX_W];
         default: idx = va[flptw_pkg::L1_SHIFT +: flptw_pkg::IDX_W];
      endcase
      return idx & flptw_pkg::IDX_MASK;
   endfunction

   flptw_pkg::state_type     state_ff, state_in;
   logic [flptw_pkg::IDX_W-1:0] cnt_ff, cnt_in;          // clear sweep position
   logic [FRAME_W-1:0]       clr_frame_ff, clr_frame_in; // frame being zeroed
   logic                     clr_boot_ff, clr_boot_in;   // root sweep after reset
   logic [NFF_W-1:0]         nff_ff, nff_in;             // next free frame
   logic [1:0]               level_ff, level_in;         // walk level / depth
   logic [FRAME_W-1:0]       frame_ff, frame_in;         // current table frame
   flptw_pkg::req_word_type  req_ff, req_in;
   logic                     leaf_pres_ff, leaf_pres_in;
   logic [PAGE_W-1:0]        leaf_page_ff, leaf_page_in;
   flptw_pkg::rsp_word_type  pend_ff, pend_in;           // result being built
   flptw_pkg::rsp_word_type  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_addr;
   logic [PHYS_BITS-1:0]     ram_wdata;
   logic [PHYS_BITS-1:0]     ram_rdata;

   // Walk decode of the entry just read
   logic [PAGE_W-1:0]        rd_page;
   logic                     link_ok;
   // Map admission
   logic [1:0]               needed;
   logic [NFF_W-1:0]         avail;
   logic                     no_frames;
   logic [PHYS_BITS-1:0]     link_entry;
   logic [PHYS_BITS-1:0]     map_leaf;

   assign rd_page  = ram_rdata[PHYS_BITS-1:flptw_pkg::OFFSET_W];
   assign link_ok  = ram_rdata[flptw_pkg::PRESENT_BIT]
                     && (rd_page < PAGE_W'(TABLE_FRAMES));
   assign needed   = flptw_pkg::LVL_LEAF - level_ff;
   assign avail    = NFF_W'(TABLE_FRAMES) - nff_ff;
   assign no_frames = (nff_ff > NFF_W'(TABLE_FRAMES)) || (avail < NFF_W'(needed));
   assign link_entry = PHYS_BITS'({clr_frame_ff, flptw_pkg::LINK_FLAGS});
   assign map_leaf = {req_ff.phys_addr[PHYS_BITS-1:flptw_pkg::OFFSET_W],
                      req_ff.entry_flags | flptw_pkg::FLAGS_W'(1)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= flptw_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         clr_frame_ff <= '0;
         clr_boot_ff  <= 1'b1;
         nff_ff       <= NFF_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_frame_ff <= clr_frame_in;
         clr_boot_ff  <= clr_boot_in;
         nff_ff       <= nff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      level_ff     <= level_in;
      frame_ff     <= frame_in;
      req_ff       <= req_in;
      leaf_pres_ff <= leaf_pres_in;
      leaf_page_ff <= leaf_page_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_frame_in = clr_frame_ff;
      clr_boot_in  = clr_boot_ff;
      nff_in       = nff_ff;
      level_in     = level_ff;
      frame_in     = frame_ff;
      req_in       = req_ff;
      leaf_pres_in = leaf_pres_ff;
      leaf_page_in = leaf_page_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_addr     = {frame_ff, level_idx(req_ff.virt_addr, level_ff)};
      ram_wdata    = '0;
      req_stall    = 1'b1;

      unique case (state_ff)
         flptw_pkg::ST_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = {clr_frame_ff, cnt_ff};
            cnt_in   = cnt_ff + flptw_pkg::IDX_W'(1);
            if (cnt_ff == flptw_pkg::IDX_LAST) begin
               clr_boot_in = 1'b0;
               state_in    = clr_boot_ff ? flptw_pkg::ST_IDLE : flptw_pkg::ST_LINK;
            end
         end

         flptw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in       = req_word;
               level_in     = flptw_pkg::LVL_ROOT;
               frame_in     = '0;
               leaf_pres_in = 1'b0;
               state_in     = flptw_pkg::ST_READ;
            end
         end

         flptw_pkg::ST_READ: begin
            // address already selected from frame and level
            state_in = flptw_pkg::ST_EVAL;
         end

         flptw_pkg::ST_EVAL: begin
            if (level_ff == flptw_pkg::LVL_LEAF) begin
               leaf_pres_in = ram_rdata[flptw_pkg::PRESENT_BIT];
               leaf_page_in = rd_page;
               state_in     = flptw_pkg::ST_DECIDE;
            end else if (link_ok) begin
               frame_in = ram_rdata[flptw_pkg::OFFSET_W +: FRAME_W];
               level_in = level_ff + 2'd1;
               state_in = flptw_pkg::ST_READ;
            end else begin
               state_in = flptw_pkg::ST_DECIDE;   // level_ff is the depth
            end
         end

         flptw_pkg::ST_DECIDE: begin
            pend_in.phys_result = '0;
            pend_in.status      = flptw_pkg::STS_OK;
            state_in            = flptw_pkg::ST_DONE;
            priority if (req_ff.action == flptw_pkg::ACT_MAP) begin
               if (no_frames) begin
                  pend_in.status = flptw_pkg::STS_NO_FRAMES;
               end else if (level_ff != flptw_pkg::LVL_LEAF) begin
                  clr_frame_in = nff_ff[FRAME_W-1:0];
                  nff_in       = nff_ff + NFF_W'(1);
                  cnt_in       = '0;
                  state_in     = flptw_pkg::ST_CLEAR;
               end else begin
                  state_in = flptw_pkg::ST_LEAF;   // remap
               end
            end else if (req_ff.action == flptw_pkg::ACT_UNMAP) begin
               if (level_ff != flptw_pkg::LVL_LEAF) begin
                  pend_in.status = flptw_pkg::STS_NOT_PRESENT;
               end else begin
                  if (!leaf_pres_ff) begin
                     pend_in.status = flptw_pkg::STS_NOT_PRESENT;
                  end
                  state_in = flptw_pkg::ST_LEAF;   // leaf written zero
               end
            end else if (req_ff.action == flptw_pkg::ACT_LOOKUP) begin
               if (level_ff != flptw_pkg::LVL_LEAF || !leaf_pres_ff) begin
                  pend_in.status = flptw_pkg::STS_NOT_PRESENT;
               end else begin
                  pend_in.phys_result = flptw_pkg::PA_W'({leaf_page_ff,
                     req_ff.virt_addr[flptw_pkg::OFFSET_W-1:0]});
               end
            end else begin
               // unused code: no effect, zero result
            end
         end

         flptw_pkg::ST_LINK: begin
            ram_we    = 1'b1;
            ram_wdata = link_entry;
            frame_in  = clr_frame_ff;
            level_in  = level_ff + 2'd1;
            if (level_ff == flptw_pkg::LVL_LAST_LINK) begin
               state_in = flptw_pkg::ST_LEAF;
            end else begin
               clr_frame_in = nff_ff[FRAME_W-1:0];
               nff_in       = nff_ff + NFF_W'(1);
               cnt_in       = '0;
               state_in     = flptw_pkg::ST_CLEAR;
            end
         end

         flptw_pkg::ST_LEAF: begin
            ram_we    = 1'b1;
            ram_wdata = (req_ff.action == flptw_pkg::ACT_MAP) ? map_leaf : '0;
            state_in  = flptw_pkg::ST_DONE;
         end

         flptw_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = flptw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = flptw_pkg::ST_IDLE;
         end
      endcase
   end

   flptw_ram #(
      .DATA_W (PHYS_BITS),
      .DEPTH  (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

### rtl/flptw_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the page table walker, bound to the top level.
// Depends on flptw_pkg and four_level_page_table_walker.
module flptw_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input flptw_pkg::rsp_word_type rsp_word
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // Status code three is never produced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != flptw_pkg::STS_BAD)
      else $error("illegal status code");

   // Failed requests carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != flptw_pkg::STS_OK |-> rsp_word.phys_result == '0)
      else $error("nonzero address on failed request");

   // One request at a time: busy right after accepting
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
